// ===== rtl/ptd_pkg.sv =====
// Shared constants for the trial-division primality test core.
// Fixes the widths of the stream payloads; depends on nothing.
package ptd_pkg;

  localparam int NUMBER_WIDTH    = 32;
  localparam int OUT_TDATA_WIDTH = 40;
  localparam int OUT_PAD_WIDTH   = OUT_TDATA_WIDTH - NUMBER_WIDTH - 1;

endpackage : ptd_pkg

// ===== rtl/prime_test_trial_division_core.sv =====
// Trial-division primality test core with a bit-serial remainder unit.
// Depends on ptd_pkg for the payload widths.
// Values below two are reported not prime and two or three prime straight from CHECK; larger
// values run, for each tried divisor, a bit-serial restoring division (DIV) and a remainder
// test (EVAL). Divisors run from two while their square does not exceed the value, so a large
// prime of VALUE_WIDTH bits tries about 2^(VALUE_WIDTH/2) divisors.
// One beat is in work at a time; the next is taken once the result sits in the output register.
// Reset is synchronous and clears the control state and the output valid flag only.
module prime_test_trial_division_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [31:0] number
  input  logic [ptd_pkg::NUMBER_WIDTH-1:0]     s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [31:0] tested_value, [32] is_prime, [39:33] zero
  output logic [ptd_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata
);
  import ptd_pkg::*;

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    DIV,
    EVAL,
    DONE
  } state_t;

  state_t                   state;
  logic [VALUE_WIDTH-1:0]   n;
  logic [VALUE_WIDTH-1:0]   d;
  logic [VALUE_WIDTH+1:0]   sq;
  logic [VALUE_WIDTH-1:0]   q;
  logic [VALUE_WIDTH-1:0]   rem;
  logic [CW-1:0]            cnt;
  logic                     prime;
  logic [NUMBER_WIDTH-1:0]  out_value;
  logic                     out_prime;

  logic [VALUE_WIDTH-1:0]   n_in;
  logic [NUMBER_WIDTH-1:0]  n_echo;
  logic [VALUE_WIDTH:0]     r2;
  logic [VALUE_WIDTH:0]     sub;
  logic                     fits;
  logic [VALUE_WIDTH+1:0]   sq_next;
  logic                     out_load;

  generate
    if (VALUE_WIDTH <= NUMBER_WIDTH) begin : g_narrow
      assign n_in = s_axis_tdata[VALUE_WIDTH-1:0];
    end else begin : g_wide_in
      assign n_in = {{(VALUE_WIDTH - NUMBER_WIDTH){1'b0}}, s_axis_tdata};
    end
    if (VALUE_WIDTH >= NUMBER_WIDTH) begin : g_echo_cut
      assign n_echo = n[NUMBER_WIDTH-1:0];
    end else begin : g_echo_ext
      assign n_echo = {{(NUMBER_WIDTH - VALUE_WIDTH){1'b0}}, n};
    end
  endgenerate

  // One restoring-division step: bring down the next bit of the value.
  assign r2      = {rem, q[VALUE_WIDTH-1]};
  assign fits    = (r2 >= {1'b0, d});
  assign sub     = r2 - {1'b0, d};
  // (d + 1)^2 = d^2 + 2d + 1.
  assign sq_next = sq + {1'b0, d, 1'b1};

  assign out_load      = (state == DONE) && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = (state == IDLE);
  assign m_axis_tdata  = {{OUT_PAD_WIDTH{1'b0}}, out_prime, out_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            n     <= n_in;
            d     <= VALUE_WIDTH'(2);
            sq    <= (VALUE_WIDTH + 2)'(4);
            state <= CHECK;
          end
        end
        CHECK: begin
          if (n[VALUE_WIDTH-1:1] == '0) begin
            prime <= 1'b0;
            state <= DONE;
          end else if (sq > {2'b00, n}) begin
            prime <= 1'b1;
            state <= DONE;
          end else begin
            q     <= n;
            rem   <= '0;
            cnt   <= CW'(VALUE_WIDTH);
            state <= DIV;
          end
        end
        DIV: begin
          q <= {q[VALUE_WIDTH-2:0], 1'b0};
          if (fits) begin
            rem <= sub[VALUE_WIDTH-1:0];
          end else begin
            rem <= r2[VALUE_WIDTH-1:0];
          end
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= EVAL;
          end
        end
        EVAL: begin
          if (rem == '0) begin
            prime <= 1'b0;
            state <= DONE;
          end else begin
            d     <= d + VALUE_WIDTH'(1);
            sq    <= sq_next;
            state <= CHECK;
          end
        end
        DONE: begin
          if (out_load) begin
            out_value     <= n_echo;
            out_prime     <= prime;
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_prime_ge_two: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[NUMBER_WIDTH] |-> m_axis_tdata[NUMBER_WIDTH-1:1] != '0)
    else $error("prime flag set on a value below two");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == DIV) |-> rem < d)
    else $error("partial remainder not below the divisor");

  a_divisor_from_two: assert property (@(posedge clk) disable iff (rst)
    (state == CHECK || state == DIV || state == EVAL) |-> d >= VALUE_WIDTH'(2))
    else $error("trial divisor below two");

endmodule : prime_test_trial_division_core
